>>> hw/rtl/i2c_bitbang_master_core_macros.svh
// Assertion helpers for the I2C sequencer core
`ifndef I2C_BITBANG_MASTER_CORE_MACROS_SVH
`define I2C_BITBANG_MASTER_CORE_MACROS_SVH

// Assert that a implies b on the same edge
`define IBM_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Assert that a implies b on the next edge
`define IBM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/ibm_pkg.sv
package ibm_pkg;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_WACK  = 3'd4,
        OP_READ  = 3'd5
    } t_op;

    localparam logic [1:0] CFG_TPU   = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;

    localparam logic [15:0] TPU_RESET   = 16'd50;
    localparam logic [7:0]  LIMIT_RESET = 8'd250;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       timed_out;
    } t_out_item;

endpackage

>>> hw/rtl/ibm_front.sv
// Front part: register accepted items into a small queue
module ibm_front #(
    parameter int DEPTH_LOG2 = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ibm_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_valid,
    output ibm_pkg::t_in_item o_item,
    input  logic              i_take
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    ibm_pkg::t_in_item r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wp, r_rp;
    logic [DEPTH_LOG2:0]   r_cnt;
    logic wr, rd;

    assign o_full  = (r_cnt == (DEPTH_LOG2+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_take && o_valid;

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            if (wr && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

>>> hw/rtl/ibm_back.sv
// Back part: bus sequencer, one item per step, result into output queue
module ibm_back #(
    parameter int DEPTH_LOG2 = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    input  ibm_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_empty,
    output ibm_pkg::t_out_item o_item,
    input  logic               i_pop
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    typedef enum logic [4:0] {
        S_IDLE, S_ST_A, S_ST_B, S_ST_C, S_SP_A, S_SP_B, S_SP_C, S_SP_D,
        S_W_NEXT, S_W_LOW, S_W_HIGH, S_WA_SETUP, S_WA_HIGH, S_WA_POLL,
        S_R_LOW, S_R_SAMPLE, S_R_HIGH, S_ACK_A, S_ACK_B, S_ACK_C
    } t_state;

    t_state r_st, n_st;
    logic [15:0] r_tpu, r_pre, n_pre;
    logic [7:0]  r_lim, r_poll, n_poll, r_shift, n_shift, r_rx, n_rx;
    logic [2:0]  r_ucnt, n_ucnt;
    logic [3:0]  r_bit, n_bit;
    logic r_ackc, n_ackc, r_scl, n_scl, r_sda, n_sda, r_drv, n_drv;
    logic r_to, n_to, done;

    // output queue
    ibm_pkg::t_out_item r_q [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wp, r_rp;
    logic [DEPTH_LOG2:0]   r_cnt;
    logic q_full, rd;

    assign q_full  = (r_cnt == (DEPTH_LOG2+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_q[r_rp];
    assign o_take  = i_valid && !q_full;
    assign rd      = i_pop && !o_empty;

    // delay unit counter step: computes prescaler wrap, decremented unit count and expiry
    logic [15:0] tpu_eff;
    logic        pre_wrap, dexp;
    logic [2:0]  ucnt_dec;
    always_comb begin
        tpu_eff  = (r_tpu == '0) ? 16'd1 : r_tpu;
        pre_wrap = ({1'b0, r_pre} + 17'd1) >= {1'b0, tpu_eff};
        ucnt_dec = (r_ucnt != '0) ? r_ucnt - 3'd1 : r_ucnt;
        dexp     = pre_wrap && (ucnt_dec == '0);
    end

    // sequencer next state
    always_comb begin
        n_st = r_st; n_pre = r_pre; n_ucnt = r_ucnt; n_bit = r_bit;
        n_shift = r_shift; n_poll = r_poll; n_ackc = r_ackc;
        n_scl = r_scl; n_sda = r_sda; n_drv = r_drv; n_to = r_to; n_rx = r_rx;
        done = 1'b0;
        if (r_st != S_IDLE && r_st != S_ST_A && r_st != S_SP_A && r_st != S_SP_C
            && r_st != S_W_NEXT && r_st != S_WA_POLL && r_st != S_R_SAMPLE
            && r_st != S_ACK_A) begin
            if (pre_wrap) begin
                n_pre = '0;
                n_ucnt = ucnt_dec;
            end else begin
                n_pre = r_pre + 16'd1;
            end
        end
        case (r_st)
            S_IDLE: begin
                if (i_item.op >= ibm_pkg::OP_START && i_item.op <= ibm_pkg::OP_READ)
                    n_to = 1'b0;
                case (i_item.op)
                    ibm_pkg::OP_START: begin
                        n_sda = 1'b1; n_drv = 1'b1; n_st = S_ST_A;
                    end
                    ibm_pkg::OP_STOP: begin
                        n_scl = 1'b0; n_st = S_SP_A;
                    end
                    ibm_pkg::OP_WRITE: begin
                        n_drv = 1'b1; n_scl = 1'b0; n_shift = i_item.tx_byte;
                        n_bit = '0; n_st = S_W_NEXT;
                    end
                    ibm_pkg::OP_WACK: begin
                        n_drv = 1'b0; n_sda = 1'b1; n_poll = '0;
                        n_pre = '0; n_ucnt = 3'd1; n_st = S_WA_SETUP;
                    end
                    ibm_pkg::OP_READ: begin
                        n_drv = 1'b0; n_scl = 1'b0; n_shift = '0; n_bit = '0;
                        n_ackc = i_item.send_ack; n_pre = '0; n_ucnt = 3'd5;
                        n_st = S_R_LOW;
                    end
                    default: ;
                endcase
            end
            S_ST_A: begin
                n_scl = 1'b1; n_pre = '0; n_ucnt = 3'd4; n_st = S_ST_B;
            end
            S_ST_B: if (dexp) begin
                n_sda = 1'b0; n_pre = '0; n_ucnt = 3'd4; n_st = S_ST_C;
            end
            S_ST_C: if (dexp) begin
                n_scl = 1'b0; done = 1'b1; n_st = S_IDLE;
            end
            S_SP_A: begin
                n_drv = 1'b1; n_sda = 1'b0; n_pre = '0; n_ucnt = 3'd4; n_st = S_SP_B;
            end
            S_SP_B: if (dexp) begin
                n_scl = 1'b1; n_st = S_SP_C;
            end
            S_SP_C: begin
                n_sda = 1'b1; n_pre = '0; n_ucnt = 3'd4; n_st = S_SP_D;
            end
            S_SP_D: if (dexp) begin
                done = 1'b1; n_st = S_IDLE;
            end
            S_W_NEXT: begin
                n_sda = r_shift[7]; n_shift = {r_shift[6:0], 1'b0};
                n_pre = '0; n_ucnt = 3'd5; n_st = S_W_LOW;
            end
            S_W_LOW: if (dexp) begin
                n_scl = 1'b1; n_pre = '0; n_ucnt = 3'd5; n_st = S_W_HIGH;
            end
            S_W_HIGH: if (dexp) begin
                n_scl = 1'b0; n_bit = r_bit + 4'd1;
                if (n_bit >= 4'd8) begin
                    done = 1'b1; n_st = S_IDLE;
                end else begin
                    n_st = S_W_NEXT;
                end
            end
            S_WA_SETUP: if (dexp) begin
                n_scl = 1'b1; n_pre = '0; n_ucnt = 3'd1; n_st = S_WA_HIGH;
            end
            S_WA_HIGH: if (dexp) n_st = S_WA_POLL;
            S_WA_POLL: begin
                if (!i_item.sda_sample) begin
                    n_scl = 1'b0; done = 1'b1; n_st = S_IDLE;
                end else if (r_poll >= r_lim) begin
                    n_to = 1'b1; n_scl = 1'b0; n_st = S_SP_A;
                end else begin
                    n_poll = r_poll + 8'd1;
                end
            end
            S_R_LOW: if (dexp) begin
                n_scl = 1'b1; n_st = S_R_SAMPLE;
            end
            S_R_SAMPLE: begin
                n_shift = {r_shift[6:0], i_item.sda_sample};
                n_pre = '0; n_ucnt = 3'd5; n_st = S_R_HIGH;
            end
            S_R_HIGH: if (dexp) begin
                n_scl = 1'b0; n_bit = r_bit + 4'd1;
                if (n_bit >= 4'd8) begin
                    n_rx = r_shift; n_st = S_ACK_A;
                end else begin
                    n_pre = '0; n_ucnt = 3'd5; n_st = S_R_LOW;
                end
            end
            S_ACK_A: begin
                n_drv = 1'b1; n_sda = !r_ackc; n_pre = '0; n_ucnt = 3'd2;
                n_st = S_ACK_B;
            end
            S_ACK_B: if (dexp) begin
                n_scl = 1'b1; n_pre = '0; n_ucnt = 3'd2; n_st = S_ACK_C;
            end
            S_ACK_C: if (dexp) begin
                n_scl = 1'b0; done = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    // state, config and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_pre <= '0; r_ucnt <= '0; r_bit <= '0;
            r_shift <= '0; r_poll <= '0; r_ackc <= 1'b0;
            r_scl <= 1'b1; r_sda <= 1'b1; r_drv <= 1'b1; r_to <= 1'b0;
            r_rx <= '0; r_tpu <= ibm_pkg::TPU_RESET; r_lim <= ibm_pkg::LIMIT_RESET;
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == ibm_pkg::CFG_TPU) r_tpu <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == ibm_pkg::CFG_LIMIT) r_lim <= i_cfg_data[7:0];
            if (o_take) begin
                r_st <= n_st; r_pre <= n_pre; r_ucnt <= n_ucnt; r_bit <= n_bit;
                r_shift <= n_shift; r_poll <= n_poll; r_ackc <= n_ackc;
                r_scl <= n_scl; r_sda <= n_sda; r_drv <= n_drv; r_to <= n_to;
                r_rx <= n_rx;
                r_wp <= r_wp + 1'b1;
            end
            if (rd) r_rp <= r_rp + 1'b1;
            if (o_take && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !o_take) r_cnt <= r_cnt - 1'b1;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_q[r_wp] <= '{scl_level: n_scl, sda_level: n_sda, sda_drive: n_drv,
                           busy_res: (n_st != S_IDLE), done_res: done,
                           read_data: n_rx, timed_out: n_to};
        end
    end
endmodule

>>> hw/rtl/i2c_bitbang_master_core.sv
// I2C bit-bang master sequencer.
// Input queue: one item per clock tick of bus timing (op, tx_byte, send_ack,
// sda_sample), pushed with push while full is low.
// Result queue: one item per input item (line levels, busy, done, read
// data, timeout); valid while empty is low, taken with pop.
// A two-entry front queue registers items; the back sequencer takes one
// per cycle while its output queue has room and writes its result into a
// two-entry output queue, from which it can be popped. An accepted item
// is registered first in the front queue and then in the output queue.
// Throughput: 1 item per cycle while the output queue has room.
// When the receiver stops popping, the output queue fills, the sequencer
// holds, then the input queue fills and full rises; nothing is lost.
// Reset (synchronous, active low) empties both queues, puts the sequencer
// idle with SCL/SDA high and driven, and loads register defaults
// (ticks_per_unit 50, ack_poll_limit 250).
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 ticks, 1 limit).
`include "i2c_bitbang_master_core_macros.svh"
module i2c_bitbang_master_core #(
    parameter int DEPTH_LOG2 = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ibm_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output ibm_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    logic f_valid, take;
    ibm_pkg::t_in_item f_item;

    ibm_front #(.DEPTH_LOG2(DEPTH_LOG2)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_item, .o_full(full),
        .o_valid(f_valid), .o_item(f_item), .i_take(take)
    );

    ibm_back #(.DEPTH_LOG2(DEPTH_LOG2)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(f_valid), .i_item(f_item), .o_take(take),
        .o_empty(empty), .o_item, .i_pop(pop)
    );

    `IBM_ASSERT_IMPL(a_take_valid, i_clk, i_rst_n, take, f_valid)
    `IBM_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, !empty && o_item.done_res, !o_item.busy_res)
    `IBM_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, full && !take, full)
endmodule

>>> tb/tb_i2c_bitbang_master_core.sv
module tb_i2c_bitbang_master_core;

    // Sequencer phases of the predictor
    typedef enum logic [4:0] {
        S_IDLE, S_ST_A, S_ST_B, S_ST_C, S_SP_A, S_SP_B, S_SP_C, S_SP_D,
        S_W_NEXT, S_W_LOW, S_W_HIGH, S_WA_SETUP, S_WA_HIGH, S_WA_POLL,
        S_R_LOW, S_R_SAMPLE, S_R_HIGH, S_ACK_A, S_ACK_B, S_ACK_C
    } t_seq_phase;

    localparam int LIMIT_CYCLES = 4000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    ibm_pkg::t_in_item  i_item = '0;
    logic               empty;
    logic               pop = 1'b0;
    ibm_pkg::t_out_item o_item;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;

    i2c_bitbang_master_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_item(o_item), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state
    logic [15:0] m_tpu = ibm_pkg::TPU_RESET;
    logic [7:0]  m_limit = ibm_pkg::LIMIT_RESET;
    t_seq_phase  m_ph = S_IDLE;
    logic [15:0] m_pre = '0;
    logic [2:0]  m_units = '0;
    logic [3:0]  m_bit = '0;
    logic [7:0]  m_shift = '0;
    logic [7:0]  m_polls = '0;
    logic        m_ack = 1'b0;
    logic        m_scl = 1'b1, m_sda = 1'b1, m_drv = 1'b1;
    logic        m_tmo = 1'b0;
    logic [7:0]  m_rx = '0;

    ibm_pkg::t_in_item  pending_items[$];
    ibm_pkg::t_out_item expected_lines[$];
    int        errors = 0;
    int        cycle_count = 0;
    bit        hold_sender = 1'b0;
    bit        in_fire = 1'b0;
    int        send_gap = 0;
    int        pop_gap = 0;

    function automatic void load_units(input logic [2:0] n);
        m_pre = '0;
        m_units = n;
    endfunction

    // One tick of the running delay; true on expiry
    function automatic bit delay_tick();
        logic [16:0] tpu;
        tpu = (m_tpu == 0) ? 17'd1 : {1'b0, m_tpu};
        if ({1'b0, m_pre} + 17'd1 >= tpu) begin
            m_pre = '0;
            if (m_units > 0) m_units = m_units - 1'b1;
            return m_units == 0;
        end
        m_pre = m_pre + 1'b1;
        return 1'b0;
    endfunction

    function automatic ibm_pkg::t_out_item step_bus(input ibm_pkg::t_in_item it);
        ibm_pkg::t_out_item r;
        bit done;
        done = 1'b0;
        case (m_ph)
            S_IDLE: begin
                if (it.op >= ibm_pkg::OP_START && it.op <= ibm_pkg::OP_READ) m_tmo = 1'b0;
                case (it.op)
                    ibm_pkg::OP_START: begin
                        m_sda = 1'b1; m_drv = 1'b1; m_ph = S_ST_A;
                    end
                    ibm_pkg::OP_STOP: begin
                        m_scl = 1'b0; m_ph = S_SP_A;
                    end
                    ibm_pkg::OP_WRITE: begin
                        m_drv = 1'b1; m_scl = 1'b0; m_shift = it.tx_byte;
                        m_bit = '0; m_ph = S_W_NEXT;
                    end
                    ibm_pkg::OP_WACK: begin
                        m_drv = 1'b0; m_sda = 1'b1; m_polls = '0;
                        load_units(3'd1); m_ph = S_WA_SETUP;
                    end
                    ibm_pkg::OP_READ: begin
                        m_drv = 1'b0; m_scl = 1'b0; m_shift = '0; m_bit = '0;
                        m_ack = it.send_ack; load_units(3'd5); m_ph = S_R_LOW;
                    end
                    default: ;
                endcase
            end
            S_ST_A: begin
                m_scl = 1'b1; load_units(3'd4); m_ph = S_ST_B;
            end
            S_ST_B: if (delay_tick()) begin
                m_sda = 1'b0; load_units(3'd4); m_ph = S_ST_C;
            end
            S_ST_C: if (delay_tick()) begin
                m_scl = 1'b0; done = 1'b1; m_ph = S_IDLE;
            end
            S_SP_A: begin
                m_drv = 1'b1; m_sda = 1'b0; load_units(3'd4); m_ph = S_SP_B;
            end
            S_SP_B: if (delay_tick()) begin
                m_scl = 1'b1; m_ph = S_SP_C;
            end
            S_SP_C: begin
                m_sda = 1'b1; load_units(3'd4); m_ph = S_SP_D;
            end
            S_SP_D: if (delay_tick()) begin
                done = 1'b1; m_ph = S_IDLE;
            end
            S_W_NEXT: begin
                m_sda = m_shift[7]; m_shift = m_shift << 1;
                load_units(3'd5); m_ph = S_W_LOW;
            end
            S_W_LOW: if (delay_tick()) begin
                m_scl = 1'b1; load_units(3'd5); m_ph = S_W_HIGH;
            end
            S_W_HIGH: if (delay_tick()) begin
                m_scl = 1'b0; m_bit = m_bit + 1'b1;
                if (m_bit >= 8) begin
                    done = 1'b1; m_ph = S_IDLE;
                end else m_ph = S_W_NEXT;
            end
            S_WA_SETUP: if (delay_tick()) begin
                m_scl = 1'b1; load_units(3'd1); m_ph = S_WA_HIGH;
            end
            S_WA_HIGH: if (delay_tick()) m_ph = S_WA_POLL;
            S_WA_POLL: begin
                if (!it.sda_sample) begin
                    m_scl = 1'b0; done = 1'b1; m_ph = S_IDLE;
                end else if (m_polls >= m_limit) begin
                    m_tmo = 1'b1; m_scl = 1'b0; m_ph = S_SP_A;
                end else m_polls = m_polls + 1'b1;
            end
            S_R_LOW: if (delay_tick()) begin
                m_scl = 1'b1; m_ph = S_R_SAMPLE;
            end
            S_R_SAMPLE: begin
                m_shift = {m_shift[6:0], it.sda_sample};
                load_units(3'd5); m_ph = S_R_HIGH;
            end
            S_R_HIGH: if (delay_tick()) begin
                m_scl = 1'b0; m_bit = m_bit + 1'b1;
                if (m_bit >= 8) begin
                    m_rx = m_shift; m_ph = S_ACK_A;
                end else begin
                    load_units(3'd5); m_ph = S_R_LOW;
                end
            end
            S_ACK_A: begin
                m_drv = 1'b1; m_sda = !m_ack; load_units(3'd2); m_ph = S_ACK_B;
            end
            S_ACK_B: if (delay_tick()) begin
                m_scl = 1'b1; load_units(3'd2); m_ph = S_ACK_C;
            end
            S_ACK_C: if (delay_tick()) begin
                m_scl = 1'b0; done = 1'b1; m_ph = S_IDLE;
            end
            default: m_ph = S_IDLE;
        endcase
        r.scl_level = m_scl;
        r.sda_level = m_sda;
        r.sda_drive = m_drv;
        r.busy_res = (m_ph != S_IDLE);
        r.done_res = done;
        r.read_data = m_rx;
        r.timed_out = m_tmo;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Driver: one item per accepted push, random gaps (possibly none) between
    always @(negedge i_clk) begin
        int gap;
        gap = send_gap;
        if (in_fire) begin
            void'(pending_items.pop_front());
            gap = pick_gap();
        end else if (gap > 0) gap = gap - 1;
        send_gap <= gap;
        if (!i_rst_n || hold_sender || pending_items.size() == 0) push <= 1'b0;
        else if (gap == 0) begin
            push <= 1'b1;
            i_item <= pending_items[0];
        end else push <= 1'b0;
        pop <= i_rst_n && (pop_gap == 0 ? ($urandom_range(0, 3) != 0) : 1'b0);
        pop_gap <= (pop_gap > 0) ? pop_gap - 1 : pick_gap();
    end

    // Monitor: predict on accepted items, check accepted results
    always @(posedge i_clk) begin
        ibm_pkg::t_out_item exp_r;
        cycle_count <= cycle_count + 1;
        in_fire <= i_rst_n && push && !full;
        if (i_rst_n && push && !full) expected_lines.push_back(step_bus(i_item));
        if (i_rst_n && pop && !empty) begin
            if (expected_lines.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                exp_r = expected_lines.pop_front();
                if (o_item.scl_level !== exp_r.scl_level) begin
                    $error("scl_level exp %0d got %0d", exp_r.scl_level, o_item.scl_level);
                    errors++;
                end
                if (o_item.sda_level !== exp_r.sda_level) begin
                    $error("sda_level exp %0d got %0d", exp_r.sda_level, o_item.sda_level);
                    errors++;
                end
                if (o_item.sda_drive !== exp_r.sda_drive) begin
                    $error("sda_drive exp %0d got %0d", exp_r.sda_drive, o_item.sda_drive);
                    errors++;
                end
                if (o_item.busy_res !== exp_r.busy_res) begin
                    $error("busy_res exp %0d got %0d", exp_r.busy_res, o_item.busy_res);
                    errors++;
                end
                if (o_item.done_res !== exp_r.done_res) begin
                    $error("done_res exp %0d got %0d", exp_r.done_res, o_item.done_res);
                    errors++;
                end
                if (o_item.read_data !== exp_r.read_data) begin
                    $error("read_data exp %0h got %0h", exp_r.read_data, o_item.read_data);
                    errors++;
                end
                if (o_item.timed_out !== exp_r.timed_out) begin
                    $error("timed_out exp %0d got %0d", exp_r.timed_out, o_item.timed_out);
                    errors++;
                end
            end
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("i2c_bitbang_master_core verification failed");
            $finish;
        end
    end

    function automatic ibm_pkg::t_in_item mk(input ibm_pkg::t_op op, input logic [7:0] tx,
                                             input logic ack, input logic sda);
        ibm_pkg::t_in_item it;
        it.op = op; it.tx_byte = tx; it.send_ack = ack; it.sda_sample = sda;
        return it;
    endfunction

    // Queue idle ticks with random sda and stray commands
    task automatic add_ticks(input int n, input int sda_low_pct);
        ibm_pkg::t_in_item it;
        repeat (n) begin
            it.op = ($urandom_range(0, 99) < 10) ? 3'($urandom_range(0, 7)) : ibm_pkg::OP_NONE;
            it.tx_byte = 8'($urandom);
            it.send_ack = 1'($urandom);
            it.sda_sample = ($urandom_range(0, 99) >= sda_low_pct);
            pending_items.push_back(it);
        end
    endtask

    // Queue one command followed by the given number of idle ticks
    task automatic add_cmd(input ibm_pkg::t_op op, input int ticks, input int sda_low_pct);
        pending_items.push_back(mk(op, 8'($urandom), 1'($urandom), 1'($urandom)));
        add_ticks(ticks, sda_low_pct);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ibm_pkg::CFG_TPU) m_tpu = val;
        else m_limit = val[7:0];
    endtask

    initial begin
        int budget;
        int k;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes at fast timing
        write_reg(ibm_pkg::CFG_TPU, 16'd1);
        write_reg(ibm_pkg::CFG_LIMIT, 16'd0);
        pending_items.push_back(mk(ibm_pkg::OP_START, 8'h00, 1'b0, 1'b1));
        add_ticks(10, 0);
        pending_items.push_back(mk(ibm_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b0));
        add_ticks(6, 0);
        pending_items.push_back(mk(ibm_pkg::OP_START, 8'h00, 1'b0, 1'b0));
        add_ticks(2, 0);
        pending_items.push_back(mk(ibm_pkg::t_op'(3'd7), 8'h00, 1'b0, 1'b1));
        pending_items.push_back(mk(ibm_pkg::t_op'(3'd6), 8'hFF, 1'b1, 1'b0));
        wait_drained();
        add_cmd(ibm_pkg::OP_WACK, 12, 0);
        add_cmd(ibm_pkg::OP_READ, 100, 50);
        add_cmd(ibm_pkg::OP_STOP, 12, 50);
        add_cmd(ibm_pkg::OP_WRITE, 100, 50);
        add_cmd(ibm_pkg::OP_WACK, 10, 100);
        wait_drained();

        // Random phases with different settings
        write_reg(ibm_pkg::CFG_TPU, 16'd0);
        write_reg(ibm_pkg::CFG_LIMIT, 16'd120);
        for (k = 0; k < 2; k++)
            add_cmd(ibm_pkg::t_op'($urandom_range(1, 5)), $urandom_range(5, 60), 30);
        add_cmd(ibm_pkg::OP_WACK, 135, 0);
        wait_drained();
        write_reg(ibm_pkg::CFG_LIMIT, 16'd3);
        write_reg(ibm_pkg::CFG_TPU, 16'd2);
        budget = 60;
        while (budget > 0) begin
            k = $urandom_range(20, 120);
            add_cmd(ibm_pkg::t_op'($urandom_range(1, 5)), k, $urandom_range(0, 100));
            budget -= k + 1;
        end
        // Pause the sender mid-stream until every result is back
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b1;
        while (expected_lines.size() != 0) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();
        write_reg(ibm_pkg::CFG_TPU, 16'hFFFF);
        write_reg(ibm_pkg::CFG_LIMIT, 16'd1);
        add_cmd(ibm_pkg::OP_START, 30, 50);
        wait_drained();
        write_reg(ibm_pkg::CFG_TPU, 16'd1);
        write_reg(ibm_pkg::CFG_LIMIT, 16'd2);
        add_ticks(20, 50);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_lines.size() == 0)
            $display("i2c_bitbang_master_core verification clean");
        else
            $display("i2c_bitbang_master_core verification failed");
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ibm_pkg.sv
hw/rtl/ibm_front.sv
hw/rtl/ibm_back.sv
hw/rtl/i2c_bitbang_master_core.sv
tb/tb_i2c_bitbang_master_core.sv
